/* rtl/core/sn2d_pkg.sv */
// Shared types, constants and helper functions for the 2-D simplex noise block.
// No dependencies; used by every file under rtl/core except sn2d_checker.
`timescale 1ns / 1ps

package sn2d_pkg;

   localparam int PERM_SIZE           = 256;
   localparam int PERM_AW             = $clog2(PERM_SIZE);
   localparam int COORD_FRAC_BITS_DEF = 16;

   // Skew and unskew factors and fixed-point units, all Q30, and the integer output scale
   localparam logic signed [29:0] SKEW_Q30   = 30'sd393016785;
   localparam logic signed [28:0] UNSKEW_Q30 = 29'sd226908346;
   localparam int                 ONE_Q30    = 1073741824;
   localparam int                 HALF_Q30   = 536870912;
   localparam int                 NOISE_SCALE = 70;

   // Offset, term and sum widths of the corner datapath
   localparam int OFS_W  = 36;
   localparam int DX_W   = 32;
   localparam int DOT_W  = 33;
   localparam int TERM_W = 31;
   localparam int SUM_W  = 33;

   // Evaluate pipeline: accept to result strobe
   localparam int PIPE_LEN   = 15;

   typedef enum logic {
      ACTION_LOAD = 1'b0,
      ACTION_EVAL = 1'b1
   } action_type;

   typedef struct packed {
      logic signed [DX_W-1:0]    dx;
      logic signed [DX_W-1:0]    dy;
      logic        [PERM_AW-1:0] hash;
   } corner_in_type;

   // Gradient code: hash modulo 12 by reciprocal multiply (exact for 8-bit hashes)
   function automatic logic [3:0] grad_code(input logic [7:0] h);
      logic [15:0] prod;
      logic [4:0]  quo;
      logic [7:0]  rem;
      prod = 16'(h) * 16'd171;
      quo  = prod[15:11];
      rem  = h - (8'(quo) * 8'd12);
      return rem[3:0];
   endfunction

   // Saturate an offset to the corner datapath width
   function automatic logic signed [DX_W-1:0] clamp_ofs(input logic signed [OFS_W-1:0] v);
      logic signed [OFS_W-1:0] hi;
      logic signed [OFS_W-1:0] lo;
      hi = OFS_W'({1'b0, {(DX_W-1){1'b1}}});
      lo = -hi - OFS_W'(1);
      if (v > hi) begin
         return hi[DX_W-1:0];
      end else if (v < lo) begin
         return lo[DX_W-1:0];
      end
      return v[DX_W-1:0];
   endfunction

endpackage

/* rtl/core/simplex_noise_2d.sv */
// Top level of the 2-D simplex noise block: skew, table hashing, corner sum, output scale.
// Depends on sn2d_pkg, sn2d_perm_mem and sn2d_corner.
// A result strobe follows each accepted evaluate item, in order of acceptance.
// Throughput: one item per cycle while busy is low; a load is held off after an
// evaluate, until that evaluate has issued its table reads (the memory ports set this).
// Reset clears the pipeline valid bits only; the permutation table keeps its content.
// Results cannot be stalled: each is shown for one cycle on rsp_valid.
`timescale 1ns / 1ps

module simplex_noise_2d #(
   parameter int COORD_FRAC_BITS = sn2d_pkg::COORD_FRAC_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_action,
   input  logic [7:0]          req_table_index,
   input  logic [7:0]          req_table_value,
   input  logic signed [31:0]  req_x_coord,
   input  logic signed [31:0]  req_y_coord,
   output logic                rsp_valid,
   output logic signed [15:0]  rsp_noise_value
);

   localparam int F      = COORD_FRAC_BITS;
   localparam int CELL_W = 34 - F;
   localparam int CT_W   = CELL_W + 30;
   localparam int AW     = sn2d_pkg::PERM_AW;
   localparam int OW     = sn2d_pkg::OFS_W;

   logic accept;
   logic eval_accept;
   logic [sn2d_pkg::PIPE_LEN:1] vld_ff, vld_in;

   // Accept and hazard interlock: hold a load while an evaluate still has table reads ahead
   assign busy        = (req_action == sn2d_pkg::ACTION_LOAD) &&
                        (|vld_ff[4:1]);
   assign accept      = start && !busy;
   assign eval_accept = accept && (req_action == sn2d_pkg::ACTION_EVAL);

   assign vld_in = {vld_ff[sn2d_pkg::PIPE_LEN-1:1], eval_accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // stage 1: capture coordinates
   logic signed [31:0] x1_ff, y1_ff;
   always_ff @(posedge clock) begin
      x1_ff <= req_x_coord;
      y1_ff <= req_y_coord;
   end

   // stage 2: x + y
   logic signed [31:0] x2_ff, y2_ff;
   logic signed [32:0] sxy2_ff;
   always_ff @(posedge clock) begin
      x2_ff   <= x1_ff;
      y2_ff   <= y1_ff;
      sxy2_ff <= 33'(x1_ff) + 33'(y1_ff);
   end

   // stage 3: skew product, exact
   logic signed [31:0] x3_ff, y3_ff;
   logic signed [63:0] sk3_ff, sk3_in;
   assign sk3_in = sxy2_ff * sn2d_pkg::SKEW_Q30;
   always_ff @(posedge clock) begin
      x3_ff  <= x2_ff;
      y3_ff  <= y2_ff;
      sk3_ff <= sk3_in;
   end

   // stage 4: cell indexes by floor of the skewed point
   logic signed [63:0]       accx, accy;
   logic signed [CELL_W-1:0] ci4_ff, cj4_ff;
   logic signed [31:0]       x4_ff, y4_ff;
   assign accx = {{2{x3_ff[31]}}, x3_ff, 30'b0} + sk3_ff;
   assign accy = {{2{y3_ff[31]}}, y3_ff, 30'b0} + sk3_ff;
   always_ff @(posedge clock) begin
      ci4_ff <= accx[63:30+F];
      cj4_ff <= accy[63:30+F];
      x4_ff  <= x3_ff;
      y4_ff  <= y3_ff;
   end

   // stage 5: first-level table reads issue here; order the middle corner
   logic signed [63:0]     bx, by;
   logic signed [63:0]     bx5_ff, by5_ff;
   logic signed [CELL_W:0] cs5_ff;
   logic                   i15_ff;
   logic [AW-1:0]          ii5_ff;
   logic [AW-1:0]          jj4, jj4p;
   assign bx   = (64'(x4_ff) <<< (30 - F)) - (64'(ci4_ff) <<< 30);
   assign by   = (64'(y4_ff) <<< (30 - F)) - (64'(cj4_ff) <<< 30);
   assign jj4  = cj4_ff[AW-1:0];
   assign jj4p = jj4 + AW'(1);
   always_ff @(posedge clock) begin
      bx5_ff <= bx;
      by5_ff <= by;
      cs5_ff <= (CELL_W+1)'(ci4_ff) + (CELL_W+1)'(cj4_ff);
      i15_ff <= bx > by;
      ii5_ff <= ci4_ff[AW-1:0];
   end

   // stage 6: hash reads issue from the first-level data; unskew product
   logic [4:0][AW-1:0] rd_addr;
   logic [4:0][7:0]    rd_data;
   logic signed [CT_W-1:0] ct6_in;
   logic signed [CT_W-1:0] ct6_ff;
   logic signed [63:0]     bx6_ff, by6_ff;
   logic                   i16_ff;

   assign rd_addr[0] = jj4;
   assign rd_addr[1] = jj4p;
   assign rd_addr[2] = ii5_ff + rd_data[0];
   assign rd_addr[3] = ii5_ff + rd_data[1] + AW'(1);
   assign rd_addr[4] = i15_ff ? (ii5_ff + rd_data[0] + AW'(1)) : (ii5_ff + rd_data[1]);
   assign ct6_in     = cs5_ff * sn2d_pkg::UNSKEW_Q30;

   always_ff @(posedge clock) begin
      ct6_ff <= ct6_in;
      bx6_ff <= bx5_ff;
      by6_ff <= by5_ff;
      i16_ff <= i15_ff;
   end

   sn2d_perm_mem u_perm (
      .clock   (clock),
      .wr_en   (accept && (req_action == sn2d_pkg::ACTION_LOAD)),
      .wr_addr (req_table_index[AW-1:0]),
      .wr_data (req_table_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // stage 7: first corner offsets; capture hashes
   logic signed [63:0]   x0w, y0w;
   logic signed [OW-1:0] x07_ff, y07_ff;
   logic                 i17_ff;
   logic [AW-1:0]        h07_ff, h17_ff, h27_ff;
   assign x0w = bx6_ff + 64'(ct6_ff);
   assign y0w = by6_ff + 64'(ct6_ff);
   always_ff @(posedge clock) begin
      x07_ff <= x0w[OW-1:0];
      y07_ff <= y0w[OW-1:0];
      i17_ff <= i16_ff;
      h07_ff <= rd_data[2];
      h27_ff <= rd_data[3];
      h17_ff <= rd_data[4];
   end

   // stage 8: remaining corner offsets, saturate into the corner datapath
   localparam logic signed [OW-1:0] ONE_O    = OW'(sn2d_pkg::ONE_Q30);
   localparam logic signed [OW-1:0] UNSKEW_O = OW'(sn2d_pkg::UNSKEW_Q30);
   logic signed [OW-1:0]  x1o, y1o, x2o, y2o;
   sn2d_pkg::corner_in_type c0_ff, c1_ff, c2_ff;
   assign x1o = x07_ff - (i17_ff ? ONE_O : '0) + UNSKEW_O;
   assign y1o = y07_ff - (i17_ff ? '0 : ONE_O) + UNSKEW_O;
   assign x2o = x07_ff - ONE_O + (UNSKEW_O <<< 1);
   assign y2o = y07_ff - ONE_O + (UNSKEW_O <<< 1);
   always_ff @(posedge clock) begin
      c0_ff <= '{dx: sn2d_pkg::clamp_ofs(x07_ff), dy: sn2d_pkg::clamp_ofs(y07_ff), hash: h07_ff};
      c1_ff <= '{dx: sn2d_pkg::clamp_ofs(x1o), dy: sn2d_pkg::clamp_ofs(y1o), hash: h17_ff};
      c2_ff <= '{dx: sn2d_pkg::clamp_ofs(x2o), dy: sn2d_pkg::clamp_ofs(y2o), hash: h27_ff};
   end

   // stages 9 to 13: corner terms
   logic signed [sn2d_pkg::TERM_W-1:0] term0, term1, term2;
   sn2d_corner u_corner0 (.clock(clock), .corner(c0_ff), .term(term0));
   sn2d_corner u_corner1 (.clock(clock), .corner(c1_ff), .term(term1));
   sn2d_corner u_corner2 (.clock(clock), .corner(c2_ff), .term(term2));

   // stage 14: sum
   logic signed [sn2d_pkg::SUM_W-1:0] sum_ff;
   always_ff @(posedge clock) begin
      sum_ff <= sn2d_pkg::SUM_W'(term0) + sn2d_pkg::SUM_W'(term1) + sn2d_pkg::SUM_W'(term2);
   end

   // stage 15: scale by 70, round half up to Q15, saturate
   logic signed [39:0] scaled;
   logic signed [24:0] rnd;
   logic signed [15:0] noise_in, noise_ff;
   assign scaled = 40'(sum_ff) * 40'(sn2d_pkg::NOISE_SCALE) + 40'sd16384;
   assign rnd    = scaled[39:15];
   always_comb begin
      if (rnd > 25'sd32767) begin
         noise_in = 16'sh7fff;
      end else if (rnd < -25'sd32768) begin
         noise_in = 16'sh8000;
      end else begin
         noise_in = rnd[15:0];
      end
   end
   always_ff @(posedge clock) begin
      noise_ff <= noise_in;
   end

   assign rsp_valid       = vld_ff[sn2d_pkg::PIPE_LEN];
   assign rsp_noise_value = noise_ff;

endmodule

/* rtl/core/sn2d_perm_mem.sv */
// Permutation table storage: one write port, copies for five registered reads a cycle.
// Depends on sn2d_pkg.
`timescale 1ns / 1ps

module sn2d_perm_mem (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [sn2d_pkg::PERM_AW-1:0]     wr_addr,
   input  logic [7:0]                       wr_data,
   input  logic [4:0][sn2d_pkg::PERM_AW-1:0] rd_addr,
   output logic [4:0][7:0]                  rd_data
);

   // Bank 0 serves the two first-level reads, banks 1 and 2 the hash reads
   logic [7:0] bank0_mem [sn2d_pkg::PERM_SIZE];
   logic [7:0] bank1_mem [sn2d_pkg::PERM_SIZE];
   logic [7:0] bank2_mem [sn2d_pkg::PERM_SIZE];
   logic [4:0][7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         bank0_mem[wr_addr] <= wr_data;
         bank1_mem[wr_addr] <= wr_data;
         bank2_mem[wr_addr] <= wr_data;
      end
      rd_data_ff[0] <= bank0_mem[rd_addr[0]];
      rd_data_ff[1] <= bank0_mem[rd_addr[1]];
      rd_data_ff[2] <= bank1_mem[rd_addr[2]];
      rd_data_ff[3] <= bank1_mem[rd_addr[3]];
      rd_data_ff[4] <= bank2_mem[rd_addr[4]];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/sn2d_corner.sv */
// One simplex corner: falloff to the fourth power times the gradient dot product.
// Five register stages; depends on sn2d_pkg.
`timescale 1ns / 1ps

module sn2d_corner (
   input  logic                                 clock,
   input  sn2d_pkg::corner_in_type              corner,
   output logic signed [sn2d_pkg::TERM_W-1:0]   term
);

   localparam int DW = sn2d_pkg::DX_W;

   // stage 1: squares
   logic [33:0]              sqx_ff, sqy_ff;
   logic signed [DW-1:0]     dx1_ff, dy1_ff;
   logic [7:0]               hash1_ff;
   logic signed [2*DW-1:0]   px2, py2;

   // stage 2: falloff and dot product
   logic signed [35:0]                 t_raw;
   logic [29:0]                        t_ff;
   logic                               neg2_ff;
   logic signed [sn2d_pkg::DOT_W-1:0]  dot_in, dot2_ff;
   logic signed [sn2d_pkg::DOT_W-1:0]  xt, yt;
   logic [3:0]                         gc;

   // stage 3 and 4: powers
   logic [59:0] tt_prod;
   logic [28:0] t2_ff;
   logic [57:0] t4_prod;
   logic [26:0] t4_ff;
   logic        neg3_ff, neg4_ff;
   logic signed [sn2d_pkg::DOT_W-1:0] dot3_ff, dot4_ff;

   // stage 5: term
   logic signed [60:0]               tp;
   logic signed [sn2d_pkg::TERM_W-1:0] term_ff;

   assign px2 = corner.dx * corner.dx;
   assign py2 = corner.dy * corner.dy;

   always_ff @(posedge clock) begin
      sqx_ff   <= px2[63:30];
      sqy_ff   <= py2[63:30];
      dx1_ff   <= corner.dx;
      dy1_ff   <= corner.dy;
      hash1_ff <= corner.hash;
   end

   always_comb begin
      t_raw = 36'(sn2d_pkg::HALF_Q30) - 36'(sqx_ff) - 36'(sqy_ff);
      gc    = sn2d_pkg::grad_code(hash1_ff);
      xt    = '0;
      yt    = '0;
      if (gc < 4'd8) begin
         xt = gc[0] ? -sn2d_pkg::DOT_W'(dx1_ff) : sn2d_pkg::DOT_W'(dx1_ff);
         if (gc < 4'd4) begin
            yt = gc[1] ? -sn2d_pkg::DOT_W'(dy1_ff) : sn2d_pkg::DOT_W'(dy1_ff);
         end
      end else begin
         yt = gc[0] ? -sn2d_pkg::DOT_W'(dy1_ff) : sn2d_pkg::DOT_W'(dy1_ff);
      end
      dot_in = xt + yt;
   end

   always_ff @(posedge clock) begin
      t_ff    <= t_raw[29:0];
      neg2_ff <= t_raw[35];
      dot2_ff <= dot_in;
   end

   assign tt_prod = 60'(t_ff) * 60'(t_ff);

   always_ff @(posedge clock) begin
      t2_ff   <= tt_prod[58:30];
      neg3_ff <= neg2_ff;
      dot3_ff <= dot2_ff;
   end

   assign t4_prod = 58'(t2_ff) * 58'(t2_ff);

   always_ff @(posedge clock) begin
      t4_ff   <= t4_prod[56:30];
      neg4_ff <= neg3_ff;
      dot4_ff <= dot3_ff;
   end

   assign tp = $signed({1'b0, t4_ff}) * dot4_ff;

   always_ff @(posedge clock) begin
      term_ff <= neg4_ff ? '0 : tp[60:30];
   end

   assign term = term_ff;

endmodule

/* rtl/core/sn2d_checker.sv */
// Port-level checks for simplex_noise_2d and the bind that attaches them.
// Depends on simplex_noise_2d.
`timescale 1ns / 1ps

module sn2d_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_action,
   input logic rsp_valid
);

   // A result only follows an accepted evaluate, as that evaluate leaves the pipeline
   a_rsp_from_eval: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy && req_action, 15))
      else $error("result without matching evaluate");

   // Only loads are ever held off
   a_busy_loads: assert property (@(posedge clock) disable iff (reset)
      busy |-> !req_action)
      else $error("evaluate held off");

   // A load right after an evaluate is held off
   a_load_after_eval: assert property (@(posedge clock) disable iff (reset)
      $past(start && !busy && req_action && !reset) |-> (busy || req_action))
      else $error("load not held after evaluate");

   // Reset empties the pipeline
   a_reset_clear: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !busy))
      else $error("pipeline not cleared by reset");

endmodule

bind simplex_noise_2d sn2d_checker u_sn2d_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_action (req_action),
   .rsp_valid  (rsp_valid)
);

/* tb/sv/tb.sv */
// Testbench for simplex_noise_2d: directed and random load/evaluate items, checked
// against an in-bench fixed-point noise predictor. Depends on sn2d_pkg and the RTL.
`timescale 1ns / 1ps

module tb;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic               req_action = 1'b0;
   logic [7:0]         req_table_index = '0;
   logic [7:0]         req_table_value = '0;
   logic signed [31:0] req_x_coord = '0;
   logic signed [31:0] req_y_coord = '0;
   logic               rsp_valid;
   logic signed [15:0] rsp_noise_value;

   localparam int FRAC = sn2d_pkg::COORD_FRAC_BITS_DEF;
   localparam int WATCHDOG_LIMIT = 2000;

   simplex_noise_2d dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_action(req_action), .req_table_index(req_table_index),
      .req_table_value(req_table_value), .req_x_coord(req_x_coord),
      .req_y_coord(req_y_coord), .rsp_valid(rsp_valid),
      .rsp_noise_value(rsp_noise_value)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // predictor state: own copy of the permutation table
   logic [7:0]         perm_copy [sn2d_pkg::PERM_SIZE];
   logic signed [15:0] noise_queue [$];
   int                 mismatches = 0;
   int                 results_seen = 0;
   int                 evals_sent = 0;
   int                 loads_sent = 0;
   int                 idle_cycles = 0;
   bit                 no_idle = 1'b0;

   function automatic longint floor_shift(longint v, int n);
      return v >>> n;
   endfunction

   function automatic longint corner_contrib(longint dx, longint dy, logic [7:0] h);
      longint t, t2, t4, dotp;
      int     g;
      int     gx [12] = '{1, -1, 1, -1, 1, -1, 1, -1, 0, 0, 0, 0};
      int     gy [12] = '{1, 1, -1, -1, 0, 0, 0, 0, 1, -1, 1, -1};
      t = longint'(sn2d_pkg::HALF_Q30) - floor_shift(dx * dx, 30)
          - floor_shift(dy * dy, 30);
      g = int'(h) % 12;
      if (t < 0) return 0;
      t2 = floor_shift(t * t, 30);
      t4 = floor_shift(t2 * t2, 30);
      dotp = longint'(gx[g]) * dx + longint'(gy[g]) * dy;
      return floor_shift(t4 * dotp, 30);
   endfunction

   function automatic logic signed [15:0] predict_noise(logic signed [31:0] xc,
                                                        logic signed [31:0] yc);
      longint x, y, sk, ci, cj, ct, x0, y0, x1, y1, x2, y2, sum, r;
      longint one, skew, unskew;
      int     i1, j1;
      logic [7:0] ii, jj, h0, h1, h2;
      one = longint'(sn2d_pkg::ONE_Q30);
      skew = 64'sd393016785;
      unskew = 64'sd226908346;
      x = xc;
      y = yc;
      sk = (x + y) * skew;
      ci = floor_shift(x * one + sk, 30 + FRAC);
      cj = floor_shift(y * one + sk, 30 + FRAC);
      ct = (ci + cj) * unskew;
      x0 = x * (longint'(1) <<< (30 - FRAC)) - ci * one + ct;
      y0 = y * (longint'(1) <<< (30 - FRAC)) - cj * one + ct;
      if (x0 > y0) begin
         i1 = 1; j1 = 0;
      end else begin
         i1 = 0; j1 = 1;
      end
      x1 = x0 - i1 * one + unskew;
      y1 = y0 - j1 * one + unskew;
      x2 = x0 - one + 2 * unskew;
      y2 = y0 - one + 2 * unskew;
      ii = ci[7:0];
      jj = cj[7:0];
      h0 = perm_copy[8'(ii + perm_copy[jj])];
      h1 = perm_copy[8'(ii + 8'(i1) + perm_copy[8'(jj + 8'(j1))])];
      h2 = perm_copy[8'(ii + 8'd1 + perm_copy[8'(jj + 8'd1)])];
      sum = corner_contrib(x0, y0, h0) + corner_contrib(x1, y1, h1)
          + corner_contrib(x2, y2, h2);
      r = floor_shift(70 * sum + (longint'(1) <<< 14), 15);
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r[15:0];
   endfunction

   // Send one item: drop start while idling, drive at the edge, hold until accepted.
   task automatic send_item(logic act, logic [7:0] idx, logic [7:0] val,
                            logic signed [31:0] xc, logic signed [31:0] yc);
      if (!no_idle) begin
         while ($urandom_range(99) < 18) begin
            start <= 1'b0;
            @(posedge clock);
         end
      end
      start <= 1'b1;
      req_action <= act;
      req_table_index <= idx;
      req_table_value <= val;
      req_x_coord <= xc;
      req_y_coord <= yc;
      @(posedge clock);
      while (busy) @(posedge clock);
      // accepted at this edge; predict in order of acceptance
      if (act == sn2d_pkg::ACTION_LOAD) begin
         perm_copy[idx] = val;
         loads_sent++;
      end else begin
         noise_queue.push_back(predict_noise(xc, yc));
         evals_sent++;
      end
   endtask

   task automatic eval_point(logic signed [31:0] xc, logic signed [31:0] yc);
      send_item(sn2d_pkg::ACTION_EVAL, 8'($urandom), 8'($urandom), xc, yc);
   endtask

   // Check each strobed result against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         results_seen++;
         if (noise_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %0d", rsp_noise_value);
         end else begin
            logic signed [15:0] want;
            want = noise_queue.pop_front();
            if (want !== rsp_noise_value) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("noise mismatch: expected %0d actual %0d", want, rsp_noise_value);
            end
         end
      end
   end

   // Watchdog: count cycles with neither acceptance nor result.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired");
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // Fill the whole table: every entry is written before any evaluate.
   task automatic test_table_fill(bit identity);
      for (int k = 0; k < sn2d_pkg::PERM_SIZE; k++) begin
         send_item(sn2d_pkg::ACTION_LOAD, 8'(k), identity ? 8'(k) : 8'($urandom), '0, '0);
      end
   endtask

   task automatic test_directed();
      eval_point(32'sd0, 32'sd0);
      eval_point(32'h7fffffff, 32'h7fffffff);
      eval_point(32'h80000000, 32'h80000000);
      eval_point(32'h7fffffff, 32'h80000000);
      eval_point(32'h80000000, 32'h7fffffff);
      eval_point(32'hffffffff, 32'hffffffff);
      eval_point(32'sd32768, 32'sd16384);   // x0 > y0 ordering
      eval_point(32'sd16384, 32'sd32768);   // other ordering
      eval_point(32'sd32768, 32'sd32768);   // tie on offsets
      eval_point(-32'sd98304, -32'sd40000); // negative cells wrap
      eval_point(32'sd16777216, -32'sd16777216);
      // overwrite entries with extremes, then evaluate near origin
      send_item(sn2d_pkg::ACTION_LOAD, 8'd0, 8'hff, '0, '0);
      send_item(sn2d_pkg::ACTION_LOAD, 8'hff, 8'h00, '0, '0);
      send_item(sn2d_pkg::ACTION_LOAD, 8'd1, 8'd11, '0, '0);
      eval_point(32'sd21000, 32'sd9000);
      eval_point(-32'sd21000, 32'sd9000);
   endtask

   // Mostly evaluates with random or small coordinates, loads mixed in.
   task automatic test_random(int count);
      logic signed [31:0] xc, yc;
      for (int k = 0; k < count; k++) begin
         no_idle = (k >= count / 3 && k < count / 2);
         if ($urandom_range(99) < 15) begin
            send_item(sn2d_pkg::ACTION_LOAD, 8'($urandom), 8'($urandom),
                      32'($urandom), 32'($urandom));
         end else begin
            if ($urandom_range(3) == 0) begin
               xc = $urandom;
               yc = $urandom;
            end else begin
               xc = $signed(32'($urandom_range(2000000))) - 32'sd1000000;
               yc = $signed(32'($urandom_range(2000000))) - 32'sd1000000;
            end
            eval_point(xc, yc);
         end
      end
      no_idle = 1'b0;
   endtask

   task automatic drain();
      start <= 1'b0;
      while (noise_queue.size() != 0) @(posedge clock);
      repeat (sn2d_pkg::PIPE_LEN + 5) @(posedge clock);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_table_fill(1'b0);
      test_directed();
      drain();
      test_random(430);
      drain();
      $display("covered %0d loads and %0d evaluates, %0d results checked",
               loads_sent, evals_sent, results_seen);
      if (mismatches == 0 && noise_queue.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("mismatches: %0d, left over: %0d", mismatches, noise_queue.size());
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/core/sn2d_pkg.sv
rtl/core/sn2d_perm_mem.sv
rtl/core/sn2d_corner.sv
rtl/core/simplex_noise_2d.sv
rtl/core/sn2d_checker.sv
tb/sv/tb.sv
